>>> design/chlp_pkg.sv
`timescale 1ns / 1ps

package chlp_pkg;

  // event codes
  localparam logic [2:0] EV_PENDING   = 3'd0;
  localparam logic [2:0] EV_HEADER    = 3'd1;
  localparam logic [2:0] EV_STATUS    = 3'd2;
  localparam logic [2:0] EV_END       = 3'd3;
  localparam logic [2:0] EV_MALFORMED = 3'd4;
  localparam logic [2:0] EV_TOO_LONG  = 3'd5;

  // number parse phases
  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [15:0] PREFIX_LEN   = 16'd6;
  localparam logic [15:0] NUMBER_START = 16'd7;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;
  localparam logic [16:0] NUM_LIMIT    = 17'd9999;
  localparam logic [15:0] BUF_SIZE_RST = 16'd4096;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 40;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic       restart;
    logic [7:0] lc;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic signed [14:0] status_value;
    logic [15:0]        line_length;
  } result_t;

  // lower-case "status", indexed by character position
  function automatic logic [7:0] status_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h73;
      3'd1: ch = 8'h74;
      3'd2: ch = 8'h61;
      3'd3: ch = 8'h74;
      3'd4: ch = 8'h75;
      3'd5: ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> design/chlp_front.sv
`timescale 1ns / 1ps

module chlp_front (
  input  logic [7:0]     data_byte,
  input  logic           restart,
  output chlp_pkg::item_t item
);

  always_comb begin
    item.restart  = restart;
    item.lc       = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ?
                    (data_byte + 8'd32) : data_byte;
    item.is_cr    = (data_byte == 8'h0D);
    item.is_lf    = (data_byte == 8'h0A);
    item.is_colon = (data_byte == 8'h3A);
    item.is_blank = (data_byte == 8'h20) || (data_byte == 8'h09) ||
                    (data_byte == 8'h0B) || (data_byte == 8'h0C);
    item.is_sign  = (data_byte == 8'h2B) || (data_byte == 8'h2D);
    item.is_minus = (data_byte == 8'h2D);
    item.is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    item.digit    = data_byte[3:0];
  end

endmodule

>>> design/chlp_fifo.sv
`timescale 1ns / 1ps

module chlp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  chlp_pkg::item_t wr_item,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_en,
  output chlp_pkg::item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  chlp_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/chlp_back.sv
`timescale 1ns / 1ps

module chlp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       header_buffer_size,
  input  logic              in_valid,
  input  chlp_pkg::item_t   in_item,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output chlp_pkg::result_t out_res
);

  logic [15:0] chars_in_line;
  logic        cr_pending;
  logic        colon_seen;
  logic        prefix_match;
  logic [1:0]  number_phase;
  logic        number_negative;
  logic [13:0] number_accum;
  logic [15:0] bytes_taken;
  logic        finished;
  logic [2:0]  held_event;

  logic [15:0] chars_in_line_next;
  logic        cr_pending_next;
  logic        colon_seen_next;
  logic        prefix_match_next;
  logic [1:0]  number_phase_next;
  logic        number_negative_next;
  logic [13:0] number_accum_next;
  logic [15:0] bytes_taken_next;
  logic        finished_next;
  logic [2:0]  held_event_next;
  chlp_pkg::result_t res_next;

  logic        take;
  logic [15:0] limit;
  logic        line_end;
  logic [16:0] acc_sum;
  logic [14:0] mag;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign limit    = (header_buffer_size != 16'd0) ? header_buffer_size - 16'd1 : 16'd0;
  assign acc_sum  = {3'b000, number_accum} * 17'd10 + {13'd0, in_item.digit};
  // the line ending byte never touches the accumulator
  assign mag      = {1'b0, number_accum};

  always_comb begin
    // restart clears the parser before the byte is looked at
    chars_in_line_next   = in_item.restart ? 16'd0 : chars_in_line;
    cr_pending_next      = in_item.restart ? 1'b0 : cr_pending;
    colon_seen_next      = in_item.restart ? 1'b0 : colon_seen;
    prefix_match_next    = in_item.restart ? 1'b1 : prefix_match;
    number_phase_next    = in_item.restart ? chlp_pkg::PH_BLANK : number_phase;
    number_negative_next = in_item.restart ? 1'b0 : number_negative;
    number_accum_next    = in_item.restart ? 14'd0 : number_accum;
    bytes_taken_next     = in_item.restart ? 16'd0 : bytes_taken;
    finished_next        = in_item.restart ? 1'b0 : finished;
    held_event_next      = in_item.restart ? chlp_pkg::EV_PENDING : held_event;
    res_next.event_res    = chlp_pkg::EV_PENDING;
    res_next.status_value = '0;
    res_next.line_length  = '0;
    line_end = 1'b0;

    if (finished_next) begin
      res_next.event_res = held_event_next;
    end else if (bytes_taken_next >= limit) begin
      res_next.event_res = chlp_pkg::EV_TOO_LONG;
      finished_next      = 1'b1;
      held_event_next    = chlp_pkg::EV_TOO_LONG;
    end else begin
      bytes_taken_next = bytes_taken_next + 16'd1;
      if (cr_pending_next) begin
        if (in_item.is_lf) begin
          line_end = 1'b1;
        end else begin
          res_next.event_res = chlp_pkg::EV_MALFORMED;
          finished_next      = 1'b1;
          held_event_next    = chlp_pkg::EV_MALFORMED;
        end
      end else if (in_item.is_cr) begin
        cr_pending_next = 1'b1;
      end else if (in_item.is_lf) begin
        line_end = 1'b1;
      end else begin
        if (in_item.is_colon) begin
          colon_seen_next = 1'b1;
        end
        if ((chars_in_line_next < chlp_pkg::PREFIX_LEN) &&
            (in_item.lc != chlp_pkg::status_char(chars_in_line_next[2:0]))) begin
          prefix_match_next = 1'b0;
        end
        if ((chars_in_line_next >= chlp_pkg::NUMBER_START) &&
            (number_phase_next != chlp_pkg::PH_DONE)) begin
          if ((number_phase_next == chlp_pkg::PH_BLANK) && in_item.is_blank) begin
            number_phase_next = chlp_pkg::PH_BLANK;
          end else if ((number_phase_next == chlp_pkg::PH_BLANK) && in_item.is_sign) begin
            number_negative_next = in_item.is_minus;
            number_phase_next    = chlp_pkg::PH_SIGN;
          end else if (in_item.is_digit) begin
            number_accum_next = (acc_sum > chlp_pkg::NUM_LIMIT) ?
                                chlp_pkg::NUM_LIMIT[13:0] : acc_sum[13:0];
            number_phase_next = chlp_pkg::PH_DIGIT;
          end else begin
            number_phase_next = chlp_pkg::PH_DONE;
          end
        end
        if (chars_in_line_next != chlp_pkg::LINE_MAX) begin
          chars_in_line_next = chars_in_line_next + 16'd1;
        end
      end

      if (line_end) begin
        if (chars_in_line_next == 16'd0) begin
          res_next.event_res = chlp_pkg::EV_END;
          finished_next      = 1'b1;
          held_event_next    = chlp_pkg::EV_END;
        end else if (!colon_seen_next) begin
          res_next.event_res = chlp_pkg::EV_MALFORMED;
          finished_next      = 1'b1;
          held_event_next    = chlp_pkg::EV_MALFORMED;
        end else if (prefix_match_next && (chars_in_line_next >= chlp_pkg::PREFIX_LEN)) begin
          res_next.event_res    = chlp_pkg::EV_STATUS;
          res_next.status_value = number_negative_next ? -$signed(mag) : $signed(mag);
          res_next.line_length  = chars_in_line_next;
        end else begin
          res_next.event_res   = chlp_pkg::EV_HEADER;
          res_next.line_length = chars_in_line_next;
        end
        chars_in_line_next   = 16'd0;
        cr_pending_next      = 1'b0;
        colon_seen_next      = 1'b0;
        prefix_match_next    = 1'b1;
        number_phase_next    = chlp_pkg::PH_BLANK;
        number_negative_next = 1'b0;
        number_accum_next    = 14'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      chars_in_line   <= 16'd0;
      cr_pending      <= 1'b0;
      colon_seen      <= 1'b0;
      prefix_match    <= 1'b1;
      number_phase    <= chlp_pkg::PH_BLANK;
      number_negative <= 1'b0;
      number_accum    <= 14'd0;
      bytes_taken     <= 16'd0;
      finished        <= 1'b0;
      held_event      <= chlp_pkg::EV_PENDING;
    end else if (take) begin
      out_valid       <= 1'b1;
      chars_in_line   <= chars_in_line_next;
      cr_pending      <= cr_pending_next;
      colon_seen      <= colon_seen_next;
      prefix_match    <= prefix_match_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_accum    <= number_accum_next;
      bytes_taken     <= bytes_taken_next;
      finished        <= finished_next;
      held_event      <= held_event_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/cgi_header_line_parser.sv
`timescale 1ns / 1ps

// cgi response header line parser
// input stream: one byte of the script's response per transaction; tuser[0]
//   set on a byte clears the parser and makes that byte the first of a new
//   response
// output stream: exactly one event per input byte, in order: pending, header
//   line, status line (with parsed value), end of headers, malformed, too long
// configuration: cfg_wr_en/cfg_wr_data load header_buffer_size (reset 4096);
//   write only while no transaction is in flight
// path: the event for a byte passes through the queue write at its input
//   transaction, then the parse into the output register when the parser
//   takes it from the queue
// throughput: one byte per cycle while the output is not stalled; the parser
//   does its compare and times-ten add for a whole byte combinationally
// stalls: the output register holds while m_axis_tready is low and the parser
//   stops; the input queue of FIFO_DEPTH entries keeps taking bytes until full,
//   then s_axis_tready falls
// reset: rst clears queue, parser state and the output valid, and loads the
//   default buffer size; end of headers and errors stay until a restart byte
module cgi_header_line_parser #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] restart
  // event stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [2:0] event_res, [17:3] status_value,
                                      // [33:18] line_length, [39:34] zero
);

  logic [15:0]       header_buffer_size;
  chlp_pkg::item_t   front_item;
  chlp_pkg::item_t   queue_item;
  logic              queue_full;
  logic              queue_valid;
  logic              back_ready;
  chlp_pkg::result_t back_res;

  // buffer size register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      header_buffer_size <= chlp_pkg::BUF_SIZE_RST;
    end else if (cfg_wr_en) begin
      header_buffer_size <= cfg_wr_data;
    end
  end

  // classify each byte as it arrives
  chlp_front u_front (
    .data_byte (s_axis_tdata),
    .restart   (s_axis_tuser[0]),
    .item      (front_item)
  );

  // short queue so that the input side can run while the output stalls
  chlp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s_axis_tvalid),
    .wr_item  (front_item),
    .full     (queue_full),
    .rd_valid (queue_valid),
    .rd_en    (back_ready),
    .rd_item  (queue_item)
  );

  assign s_axis_tready = !queue_full;

  // line parser and output register
  chlp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .header_buffer_size (header_buffer_size),
    .in_valid           (queue_valid),
    .in_item            (queue_item),
    .in_ready           (back_ready),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_res            (back_res)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata = {6'd0, back_res.line_length, back_res.status_value,
                         back_res.event_res};

endmodule

>>> design/chlp_checker.sv
`timescale 1ns / 1ps

module chlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [2:0]         ev;
  logic signed [14:0] sv;
  logic [15:0]        len;

  assign ev  = m_axis_tdata[2:0];
  assign sv  = m_axis_tdata[17:3];
  assign len = m_axis_tdata[33:18];

  // output stalled holds its transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  // nothing shown in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // status value only on a status line, and within range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((ev == chlp_pkg::EV_STATUS) || (sv == 15'sd0)) &&
                      (sv >= -15'sd9999) && (sv <= 15'sd9999))
    else $error("bad status value");

  // line length only on header or status lines
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (ev != chlp_pkg::EV_HEADER) && (ev != chlp_pkg::EV_STATUS)
    |-> (len == 16'd0))
    else $error("line length on wrong event");

  // event codes past too long never appear, and padding stays zero
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ev <= chlp_pkg::EV_TOO_LONG) && (m_axis_tdata[39:34] == 6'd0))
    else $error("bad event code");

endmodule

bind cgi_header_line_parser chlp_checker u_chlp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
